// ----- src/dsps_pkg.sv -----
// Shared types, constants and helper functions for the dust sensor pulse sampler.
// No dependencies; every other file of the block imports this package.
package dsps_pkg;

    localparam int ADC_W     = 12;
    localparam int DELAY_W   = 16;
    localparam int SUM_W     = 19;
    localparam int AVG_W     = 16;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int SAMPLES_PER_BURST_DEF = 5;

    // Conversion slopes and offsets, unsigned Q4.12.
    localparam logic [15:0] SLOPE_PRI = 16'd38298;
    localparam logic [15:0] OFFS_PRI  = 16'd410;
    localparam logic [15:0] SLOPE_ALT = 16'd40229;
    localparam logic [15:0] OFFS_ALT  = 16'd512;

    localparam logic [DELAY_W-1:0] SAMPLE_DELAY_RST = 16'd280;
    localparam logic [DELAY_W-1:0] HOLD_DELAY_RST   = 16'd20;
    localparam logic [DELAY_W-1:0] REST_DELAY_RST   = 16'd9680;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_DELAY = 2'd0,
        CFG_HOLD_DELAY   = 2'd1,
        CFG_REST_DELAY   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0] sample_delay;
        logic [DELAY_W-1:0] hold_delay;
        logic [DELAY_W-1:0] rest_delay;
    } cfg_t;

    typedef struct packed {
        logic               ir_led;
        logic               sample_request;
        logic               indicator_led;
        logic               busy;
        logic               done;
        logic [AVG_W-1:0]   average_primary;
        logic [AVG_W-1:0]   average_alternate;
        logic [ADC_W-1:0]   last_sample;
        logic [COUNT_W-1:0] burst_count;
    } res_t;

    // Linear conversion of one sample, clamped at zero.
    function automatic logic [15:0] density(input logic [ADC_W-1:0] adc,
                                            input logic [15:0] slope,
                                            input logic [15:0] offs);
        logic [ADC_W+15:0] prod;
        logic [15:0]       v;
        prod = {16'd0, adc} * {{ADC_W{1'b0}}, slope};
        v    = prod[ADC_W+15:12];
        return (v > offs) ? (v - offs) : 16'd0;
    endfunction

endpackage

// ----- src/dsps_avg_div.sv -----
// Divides a burst sum by the burst length through a reciprocal multiply.
// Depends on dsps_pkg for widths.
module dsps_avg_div #(
    parameter int SAMPLES_PER_BURST = dsps_pkg::SAMPLES_PER_BURST_DEF
) (
    input  logic [dsps_pkg::SUM_W-1:0] sum_in,
    output logic [dsps_pkg::AVG_W-1:0] avg_out
);
    import dsps_pkg::*;

    // With a shift of SUM_W+6 the rounded-up reciprocal gives the exact floor
    // for every sum below 2**SUM_W and every burst length up to eight.
    localparam int SHIFT   = SUM_W + 6;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(SAMPLES_PER_BURST) - 64'd1) /
                 64'(SAMPLES_PER_BURST));

    logic [PROD_W-1:0] prod;

    assign prod    = PROD_W'(sum_in) * PROD_W'(RECIP);
    assign avg_out = prod[SHIFT +: AVG_W];

endmodule

// ----- src/dsps_core.sv -----
// Burst sequencer, sample accumulation and averaging for one tick per step.
// Depends on dsps_pkg and dsps_avg_div.
module dsps_core #(
    parameter int SAMPLES_PER_BURST = dsps_pkg::SAMPLES_PER_BURST_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       start_req,
    input  logic                       adc_valid,
    input  logic [dsps_pkg::ADC_W-1:0] adc_value,
    input  dsps_pkg::cfg_t             cfg,
    output dsps_pkg::res_t             res
);
    import dsps_pkg::*;

    localparam int IDX_W = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ON   = 3'd1,
        PH_WAIT = 3'd2,
        PH_HOLD = 3'd3,
        PH_REST = 3'd4
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [DELAY_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]   sum_pri_reg, sum_pri_next;
    logic [SUM_W-1:0]   sum_alt_reg, sum_alt_next;
    logic [AVG_W-1:0]   avg_pri_reg, avg_pri_next;
    logic [AVG_W-1:0]   avg_alt_reg, avg_alt_next;
    logic [ADC_W-1:0]   last_reg, last_next;
    logic               ind_reg, ind_next;
    logic [COUNT_W-1:0] burst_reg, burst_next;
    logic               done_w;

    logic [DELAY_W:0]   tick_inc;
    logic [IDX_W:0]     idx_inc;
    logic [AVG_W-1:0]   div_pri, div_alt;
    logic [15:0]        dens_pri, dens_alt;

    dsps_avg_div #(.SAMPLES_PER_BURST(SAMPLES_PER_BURST)) u_div_pri (
        .sum_in  (sum_pri_reg),
        .avg_out (div_pri)
    );

    dsps_avg_div #(.SAMPLES_PER_BURST(SAMPLES_PER_BURST)) u_div_alt (
        .sum_in  (sum_alt_reg),
        .avg_out (div_alt)
    );

    assign tick_inc = {1'b0, tick_reg} + {{DELAY_W{1'b0}}, 1'b1};
    assign idx_inc  = {1'b0, idx_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign dens_pri = density(adc_value, SLOPE_PRI, OFFS_PRI);
    assign dens_alt = density(adc_value, SLOPE_ALT, OFFS_ALT);

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        idx_next     = idx_reg;
        sum_pri_next = sum_pri_reg;
        sum_alt_next = sum_alt_reg;
        avg_pri_next = avg_pri_reg;
        avg_alt_next = avg_alt_reg;
        last_next    = last_reg;
        ind_next     = ind_reg;
        burst_next   = burst_reg;
        done_w       = 1'b0;

        unique case (phase_reg)
            PH_ON: begin
                if (tick_inc >= {1'b0, cfg.sample_delay}) begin
                    tick_next  = '0;
                    phase_next = PH_WAIT;
                end else begin
                    tick_next = tick_inc[DELAY_W-1:0];
                end
            end
            PH_WAIT: begin
                if (adc_valid) begin
                    last_next    = adc_value;
                    sum_pri_next = sum_pri_reg + SUM_W'(dens_pri);
                    sum_alt_next = sum_alt_reg + SUM_W'(dens_alt);
                    tick_next    = '0;
                    phase_next   = PH_HOLD;
                end
            end
            PH_HOLD: begin
                if (tick_inc >= {1'b0, cfg.hold_delay}) begin
                    tick_next  = '0;
                    phase_next = PH_REST;
                end else begin
                    tick_next = tick_inc[DELAY_W-1:0];
                end
            end
            PH_REST: begin
                if (tick_inc >= {1'b0, cfg.rest_delay}) begin
                    tick_next = '0;
                    if (idx_inc >= (IDX_W+1)'(SAMPLES_PER_BURST)) begin
                        avg_pri_next = div_pri;
                        avg_alt_next = div_alt;
                        burst_next   = burst_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
                        idx_next     = '0;
                        phase_next   = PH_IDLE;
                        done_w       = 1'b1;
                    end else begin
                        idx_next   = idx_inc[IDX_W-1:0];
                        ind_next   = ~ind_reg;
                        phase_next = PH_ON;
                    end
                end else begin
                    tick_next = tick_inc[DELAY_W-1:0];
                end
            end
            default: begin
                // Idle, and any code that means nothing, behaves as idle.
                phase_next = PH_IDLE;
                if (start_req) begin
                    sum_pri_next = '0;
                    sum_alt_next = '0;
                    idx_next     = '0;
                    ind_next     = ~ind_reg;
                    tick_next    = '0;
                    phase_next   = PH_ON;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            idx_reg     <= '0;
            sum_pri_reg <= '0;
            sum_alt_reg <= '0;
            avg_pri_reg <= '0;
            avg_alt_reg <= '0;
            last_reg    <= '0;
            ind_reg     <= 1'b0;
            burst_reg   <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            idx_reg     <= idx_next;
            sum_pri_reg <= sum_pri_next;
            sum_alt_reg <= sum_alt_next;
            avg_pri_reg <= avg_pri_next;
            avg_alt_reg <= avg_alt_next;
            last_reg    <= last_next;
            ind_reg     <= ind_next;
            burst_reg   <= burst_next;
        end
    end

    // The result reflects the state after this tick's update.
    always_comb begin
        res.ir_led            = (phase_next == PH_ON) || (phase_next == PH_WAIT) ||
                                (phase_next == PH_HOLD);
        res.sample_request    = (phase_next == PH_WAIT);
        res.indicator_led     = ind_next;
        res.busy              = (phase_next != PH_IDLE);
        res.done              = done_w;
        res.average_primary   = avg_pri_next;
        res.average_alternate = avg_alt_next;
        res.last_sample       = last_next;
        res.burst_count       = burst_next;
    end

`ifndef SYNTHESIS
    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && done_w |=> phase_reg == PH_IDLE)
        else $error("burst end did not return to idle");

    a_burst_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !done_w |=> $stable(burst_reg))
        else $error("burst count moved without a finished burst");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, idx_reg} < (IDX_W+1)'(SAMPLES_PER_BURST))
        else $error("sample index beyond burst length");

    a_sum_cleared_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_IDLE && start_req |=> sum_pri_reg == '0 && sum_alt_reg == '0)
        else $error("sums not cleared at burst start");
`endif

endmodule

// ----- src/dust_sensor_pulse_sampler_top.sv -----
// Top level of the dust sensor pulse sampler: handshake stages and configuration.
// Depends on dsps_pkg and dsps_core.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_start_req, s_adc_valid, s_adc_value
//  m_       out        m_valid / m_ready    m_ir_led ... m_burst_count
//  cfg_     in         cfg_we (no wait)     cfg_idx, cfg_wdata
//
// Each item is one tick. It is captured in an input register, then one pass of
// the sequencer logic updates the state and loads the output register. A new
// item is taken every cycle while the output register is empty or being taken.
// The throughput limit is the output register: when it holds an untaken item
// and m_ready is low, the input register holds its item and s_ready drops.
// Reset is synchronous on aresetn low; it clears the sequencer and the valid
// flags of both stages and sets the delays (sample 280, hold 20, rest 9680 ticks).
module dust_sensor_pulse_sampler_top #(
    parameter int SAMPLES_PER_BURST = dsps_pkg::SAMPLES_PER_BURST_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_start_req,
    input  logic                           s_adc_valid,
    input  logic [dsps_pkg::ADC_W-1:0]     s_adc_value,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ir_led,
    output logic                           m_sample_request,
    output logic                           m_indicator_led,
    output logic                           m_busy_res,
    output logic                           m_done_res,
    output logic [dsps_pkg::AVG_W-1:0]     m_average_primary,
    output logic [dsps_pkg::AVG_W-1:0]     m_average_alternate,
    output logic [dsps_pkg::ADC_W-1:0]     m_last_sample,
    output logic [dsps_pkg::COUNT_W-1:0]   m_burst_count,

    input  logic                           cfg_we,
    input  logic [dsps_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [dsps_pkg::DELAY_W-1:0]   cfg_wdata
);
    import dsps_pkg::*;

    // Input register.
    logic             in_vld_reg;
    logic             in_start_reg;
    logic             in_adcv_reg;
    logic [ADC_W-1:0] in_adc_reg;

    // Output register.
    logic             out_vld_reg;
    res_t             out_res_reg;

    cfg_t             cfg_reg;
    res_t             core_res;
    logic             advance;

    // The held item moves on whenever the output register is empty or being taken.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_start_reg <= s_start_req;
            in_adcv_reg  <= s_adc_valid;
            in_adc_reg   <= s_adc_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    // Delay registers; the user must write only while the block is idle (unenforced).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_delay <= SAMPLE_DELAY_RST;
            cfg_reg.hold_delay   <= HOLD_DELAY_RST;
            cfg_reg.rest_delay   <= REST_DELAY_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_SAMPLE_DELAY: cfg_reg.sample_delay <= cfg_wdata;
                CFG_HOLD_DELAY:   cfg_reg.hold_delay   <= cfg_wdata;
                CFG_REST_DELAY:   cfg_reg.rest_delay   <= cfg_wdata;
                default: begin
                    // An index past the register list writes nothing.
                end
            endcase
        end
    end

    dsps_core #(.SAMPLES_PER_BURST(SAMPLES_PER_BURST)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .start_req (in_start_reg),
        .adc_valid (in_adcv_reg),
        .adc_value (in_adc_reg),
        .cfg       (cfg_reg),
        .res       (core_res)
    );

    assign m_valid             = out_vld_reg;
    assign m_ir_led            = out_res_reg.ir_led;
    assign m_sample_request    = out_res_reg.sample_request;
    assign m_indicator_led     = out_res_reg.indicator_led;
    assign m_busy_res          = out_res_reg.busy;
    assign m_done_res          = out_res_reg.done;
    assign m_average_primary   = out_res_reg.average_primary;
    assign m_average_alternate = out_res_reg.average_alternate;
    assign m_last_sample       = out_res_reg.last_sample;
    assign m_burst_count       = out_res_reg.burst_count;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dust_sensor_pulse_sampler_top. A scoreboard class
// tracks the burst sequencer tick by tick and checks every output item.
// Depends on dsps_pkg and the RTL of the block; needs no files or arguments.
module tb_top;
    import dsps_pkg::*;

    // The block under test runs five samples per burst.
    localparam int BURST_LEN = 5;

    // Conversion of one sample into the two densities, unsigned Q4.12.
    localparam logic [15:0] PRI_SLOPE  = 16'd38298;
    localparam logic [15:0] PRI_OFFSET = 16'd410;
    localparam logic [15:0] ALT_SLOPE  = 16'd40229;
    localparam logic [15:0] ALT_OFFSET = 16'd512;

    // The receiver holds off once for a long stretch after this many items.
    localparam int PRESSURE_AT  = 60;
    localparam int PRESSURE_LEN = 120;
    // Cycles left for the two pipeline stages to drain before a register write.
    localparam int DRAIN_CYCLES = 6;
    // Mismatches are all counted, but only the first ones are printed.
    localparam int MAX_PRINTS   = 40;

    typedef enum logic [2:0] {
        SEQ_IDLE = 3'd0,
        SEQ_ON   = 3'd1,
        SEQ_WAIT = 3'd2,
        SEQ_HOLD = 3'd3,
        SEQ_REST = 3'd4
    } seq_phase_t;

    // One input item: a single microsecond tick.
    typedef struct packed {
        logic             start_req;
        logic             adc_valid;
        logic [ADC_W-1:0] adc_value;
    } tick_t;

    // Tracks the burst sequencer and holds the output items still to come.
    class dust_burst_tracker;
        logic [DELAY_W-1:0] sample_dly;
        logic [DELAY_W-1:0] hold_dly;
        logic [DELAY_W-1:0] rest_dly;
        seq_phase_t         phase;
        logic [DELAY_W-1:0] tick_cnt;
        logic [2:0]         slot;
        logic [SUM_W-1:0]   sum_pri;
        logic [SUM_W-1:0]   sum_alt;
        logic [AVG_W-1:0]   avg_pri;
        logic [AVG_W-1:0]   avg_alt;
        logic [ADC_W-1:0]   last_adc;
        logic               led_toggle;
        logic [COUNT_W-1:0] bursts;
        res_t               pending_readings[$];
        int                 mismatches;
        int                 checked;

        function new();
            sample_dly = 16'd280;
            hold_dly   = 16'd20;
            rest_dly   = 16'd9680;
            phase      = SEQ_IDLE;
            tick_cnt   = '0;
            slot       = '0;
            sum_pri    = '0;
            sum_alt    = '0;
            avg_pri    = '0;
            avg_alt    = '0;
            last_adc   = '0;
            led_toggle = 1'b0;
            bursts     = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_delay(cfg_idx_t idx, logic [DELAY_W-1:0] value);
            unique case (idx)
                CFG_SAMPLE_DELAY: sample_dly = value;
                CFG_HOLD_DELAY:   hold_dly   = value;
                CFG_REST_DELAY:   rest_dly   = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction

        // A timed phase lasts max(limit, 1) ticks. The counter is widened so that
        // a limit lowered below the count still ends the phase on this tick.
        function bit timer_expired(logic [DELAY_W-1:0] limit);
            logic [DELAY_W:0] nxt;
            nxt = {1'b0, tick_cnt} + 1'b1;
            if (nxt >= {1'b0, limit}) begin
                tick_cnt = '0;
                return 1'b1;
            end
            tick_cnt = nxt[DELAY_W-1:0];
            return 1'b0;
        endfunction

        function logic [15:0] q12_density(logic [ADC_W-1:0] adc, logic [15:0] slope,
                                          logic [15:0] offset);
            logic [31:0] prod;
            logic [15:0] scaled;
            prod   = 32'(adc) * 32'(slope);
            scaled = prod[27:12];
            return (scaled > offset) ? scaled - offset : 16'd0;
        endfunction

        function void open_cycle();
            led_toggle = ~led_toggle;
            phase      = SEQ_ON;
            tick_cnt   = '0;
        endfunction

        // Advances the sequencer by one accepted tick and queues the output item.
        function void note_tick(tick_t t);
            res_t want;
            logic fin;
            fin = 1'b0;
            unique case (phase)
                SEQ_ON: if (timer_expired(sample_dly)) phase = SEQ_WAIT;
                SEQ_WAIT: if (t.adc_valid) begin
                    last_adc = t.adc_value;
                    sum_pri  = sum_pri + q12_density(t.adc_value, PRI_SLOPE, PRI_OFFSET);
                    sum_alt  = sum_alt + q12_density(t.adc_value, ALT_SLOPE, ALT_OFFSET);
                    phase    = SEQ_HOLD;
                    tick_cnt = '0;
                end
                SEQ_HOLD: if (timer_expired(hold_dly)) phase = SEQ_REST;
                SEQ_REST: if (timer_expired(rest_dly)) begin
                    if (int'(slot) + 1 >= BURST_LEN) begin
                        avg_pri = AVG_W'(sum_pri / BURST_LEN);
                        avg_alt = AVG_W'(sum_alt / BURST_LEN);
                        bursts  = bursts + 1'b1;
                        slot    = '0;
                        phase   = SEQ_IDLE;
                        fin     = 1'b1;
                    end else begin
                        slot = slot + 1'b1;
                        open_cycle();
                    end
                end
                default: begin
                    // Idle, or an unused code that falls back to idle.
                    phase = SEQ_IDLE;
                    if (t.start_req) begin
                        sum_pri = '0;
                        sum_alt = '0;
                        slot    = '0;
                        open_cycle();
                    end
                end
            endcase
            want.ir_led            = (phase == SEQ_ON) || (phase == SEQ_WAIT) ||
                                     (phase == SEQ_HOLD);
            want.sample_request    = (phase == SEQ_WAIT);
            want.indicator_led     = led_toggle;
            want.busy              = (phase != SEQ_IDLE);
            want.done              = fin;
            want.average_primary   = avg_pri;
            want.average_alternate = avg_alt;
            want.last_sample       = last_adc;
            want.burst_count       = bursts;
            pending_readings.push_back(want);
        endfunction

        task flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("[%0t] item %0d: %s is %0h, expected %0h",
                         $time, checked, what, got, want);
        endtask

        task compare_field(string what, logic [15:0] got, logic [15:0] want);
            if (got !== want) flag_mismatch(what, got, want);
        endtask

        task check_reading(res_t got);
            res_t want;
            if (pending_readings.size() == 0) begin
                flag_mismatch("output item with nothing expected", 16'd0, 16'd0);
                return;
            end
            want = pending_readings.pop_front();
            checked++;
            compare_field("ir_led", 16'(got.ir_led), 16'(want.ir_led));
            compare_field("sample_request", 16'(got.sample_request),
                          16'(want.sample_request));
            compare_field("indicator_led", 16'(got.indicator_led),
                          16'(want.indicator_led));
            compare_field("busy_res", 16'(got.busy), 16'(want.busy));
            compare_field("done_res", 16'(got.done), 16'(want.done));
            compare_field("average_primary", got.average_primary, want.average_primary);
            compare_field("average_alternate", got.average_alternate,
                          want.average_alternate);
            compare_field("last_sample", 16'(got.last_sample), 16'(want.last_sample));
            compare_field("burst_count", got.burst_count, want.burst_count);
        endtask
    endclass

    // Clock, reset and every input of the block start at known values.
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_start_req = 1'b0;
    logic                 s_adc_valid = 1'b0;
    logic [ADC_W-1:0]     s_adc_value = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic                 m_ir_led;
    logic                 m_sample_request;
    logic                 m_indicator_led;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic [AVG_W-1:0]     m_average_primary;
    logic [AVG_W-1:0]     m_average_alternate;
    logic [ADC_W-1:0]     m_last_sample;
    logic [COUNT_W-1:0]   m_burst_count;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx     = '0;
    logic [DELAY_W-1:0]   cfg_wdata   = '0;

    dust_burst_tracker tracker;

    // Per-phase switches for idling on each side; off gives back-to-back traffic.
    bit tx_may_gap   = 1'b0;
    bit rx_may_stall = 1'b0;

    // ADC values at the extremes and at the edges where each density clamp opens.
    logic [ADC_W-1:0] adc_corners [6] = '{12'd0, 12'd4095, 12'd43, 12'd44, 12'd52, 12'd53};

    // Random phases: delay settings, length in items, and idling on each side.
    // They take in the extremes, and lower the delays while a phase is counting.
    int unsigned phase_sample [6] = '{3, 1, 65535, 2, 1, 4};
    int unsigned phase_hold   [6] = '{2, 0, 65535, 1, 65535, 3};
    int unsigned phase_rest   [6] = '{4, 0, 65535, 3, 0, 2};
    int unsigned phase_items  [6] = '{120, 90, 40, 70, 40, 70};
    bit          phase_tx_gap [6] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    bit          phase_rx_gap [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    dust_sensor_pulse_sampler_top #(
        .SAMPLES_PER_BURST(BURST_LEN)
    ) uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_start_req        (s_start_req),
        .s_adc_valid        (s_adc_valid),
        .s_adc_value        (s_adc_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ir_led           (m_ir_led),
        .m_sample_request   (m_sample_request),
        .m_indicator_led    (m_indicator_led),
        .m_busy_res         (m_busy_res),
        .m_done_res         (m_done_res),
        .m_average_primary  (m_average_primary),
        .m_average_alternate(m_average_alternate),
        .m_last_sample      (m_last_sample),
        .m_burst_count      (m_burst_count),
        .cfg_we             (cfg_we),
        .cfg_idx            (cfg_idx),
        .cfg_wdata          (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Idle lengths: mostly none, often a short gap, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic tick_t make_item(logic start, logic valid, logic [ADC_W-1:0] adc);
        tick_t t;
        t.start_req = start;
        t.adc_valid = valid;
        t.adc_value = adc;
        return t;
    endfunction

    // Offers one item and returns once it is accepted. The ready value read just
    // after the edge is the one the block presented at that edge, so the check
    // does not race with the block's own updates.
    task automatic send_tick(input tick_t t);
        s_valid     <= 1'b1;
        s_start_req <= t.start_req;
        s_adc_valid <= t.adc_valid;
        s_adc_value <= t.adc_value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_tick(t);
    endtask

    // Stops offering items and waits for every expected item to come out.
    task automatic wind_down();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all three delays, one per cycle, while nothing is in flight.
    task automatic write_delays(input logic [DELAY_W-1:0] sd, input logic [DELAY_W-1:0] hd,
                                input logic [DELAY_W-1:0] rd);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_SAMPLE_DELAY;
        cfg_wdata <= sd;
        @(posedge aclk);
        cfg_idx   <= CFG_HOLD_DELAY;
        cfg_wdata <= hd;
        @(posedge aclk);
        cfg_idx   <= CFG_REST_DELAY;
        cfg_wdata <= rd;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tracker.set_delay(CFG_SAMPLE_DELAY, sd);
        tracker.set_delay(CFG_HOLD_DELAY, hd);
        tracker.set_delay(CFG_REST_DELAY, rd);
    endtask

    // Stimulus: a directed opening, then the random phases.
    initial begin : stimulus
        tick_t t;
        int    g;
        tracker = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset delays: an idle tick, a sample strobe while idle (ignored),
        // a start, then a start and a sample strobe while busy (both ignored).
        send_tick(make_item(1'b0, 1'b0, 12'd0));
        send_tick(make_item(1'b0, 1'b1, 12'd4095));
        send_tick(make_item(1'b1, 1'b0, 12'd0));
        send_tick(make_item(1'b1, 1'b1, 12'd2048));
        send_tick(make_item(1'b0, 1'b0, 12'd0));

        // The shortest delays, written while the sample delay is still counting,
        // so the running phase ends on the next tick. A sample is offered on
        // every tick, so the burst captures the first five ADC corner values in turn.
        // Start stays high throughout: it is ignored on the burst's last tick
        // and opens a new burst on the tick after it.
        wind_down();
        write_delays(16'd1, 16'd0, 16'd0);
        for (int i = 0; i < 21; i++)
            send_tick(make_item(1'b1, 1'b1, adc_corners[(i / 4) % 6]));

        for (int p = 0; p < 6; p++) begin
            wind_down();
            write_delays(DELAY_W'(phase_sample[p]), DELAY_W'(phase_hold[p]),
                         DELAY_W'(phase_rest[p]));
            tx_may_gap   = phase_tx_gap[p];
            rx_may_stall = phase_rx_gap[p];
            repeat (phase_items[p]) begin
                if (tx_may_gap) begin
                    g = pick_gap();
                    if (g > 0) begin
                        s_valid <= 1'b0;
                        repeat (g) @(posedge aclk);
                    end
                end
                // Mostly well-formed traffic: starts when the sequencer is idle
                // and samples while it waits for one, with some of each out of
                // place and some waiting ticks with no sample.
                if (tracker.phase == SEQ_IDLE)
                    t.start_req = ($urandom_range(0, 9) < 7);
                else
                    t.start_req = ($urandom_range(0, 9) == 0);
                if (tracker.phase == SEQ_WAIT)
                    t.adc_valid = ($urandom_range(0, 9) < 6);
                else
                    t.adc_valid = ($urandom_range(0, 9) < 2);
                if ($urandom_range(0, 7) == 0)
                    t.adc_value = adc_corners[$urandom_range(0, 5)];
                else
                    t.adc_value = ADC_W'($urandom_range(0, 4095));
                send_tick(t);
            end
        end

        wind_down();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Output side: checks every accepted item and decides ready for the next
    // edge. Once, the receiver holds off for a long stretch while the sender
    // keeps offering items, so both stages fill and the input stalls.
    initial begin : result_sink
        res_t seen;
        int   stall_left;
        int   taken;
        bit   pressure_done;
        stall_left    = 0;
        taken         = 0;
        pressure_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                seen.ir_led            = m_ir_led;
                seen.sample_request    = m_sample_request;
                seen.indicator_led     = m_indicator_led;
                seen.busy              = m_busy_res;
                seen.done              = m_done_res;
                seen.average_primary   = m_average_primary;
                seen.average_alternate = m_average_alternate;
                seen.last_sample       = m_last_sample;
                seen.burst_count       = m_burst_count;
                tracker.check_reading(seen);
                taken++;
            end
            if (!pressure_done && taken >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_LEN;
            end else if (stall_left == 0 && rx_may_stall && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #1000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/dsps_pkg.sv
src/dsps_avg_div.sv
src/dsps_core.sv
src/dust_sensor_pulse_sampler_top.sv
verif/tb_top.sv
